[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BLDQ_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// Check that a condition on one edge implies another on the next edge.
`define BLDQ_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bldq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bldq_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int FUNC_W      = 3;
  localparam int VALUE_IN_W  = 32;
  localparam int POS_W       = 5;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_REPLACE    = 3'd4,
    FN_COUNT      = 3'd5,
    FN_SEARCH     = 3'd6
  } bldq_func_t;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic out_load;
  } bldq_cmd_t;

  typedef struct packed {
    logic is_search;
    logic empty;
    logic hit;
    logic last;
  } bldq_stat_t;

endpackage

`default_nettype wire

[hw/rtl/bldq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bldq_ctrl
  import bldq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output bldq_cmd_t       cmd,
  input  wire bldq_stat_t st
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = (st.is_search && !st.empty) ? S_SRCH : S_DONE;
      end
      S_SRCH: begin
        cmd.step = 1'b1;
        if (st.hit || st.last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  `BLDQ_ASSERT_NEXT(a_done_waits, clk, rst_n, state_r == S_DONE && out_valid_r && !out_tready, state_r == S_DONE && out_valid_r, "finished request left while output slot busy")

endmodule

`default_nettype wire

[hw/rtl/bldq_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bldq_dp
  import bldq_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic        [FUNC_W-1:0]     in_func,
  input  wire logic signed [VALUE_IN_W-1:0] in_value,
  input  wire logic        [POS_W-1:0]      in_position,
  input  wire bldq_cmd_t                    cmd,
  output bldq_stat_t                        st,
  output logic             [STATUS_W-1:0]   out_status,
  output logic                              out_found,
  output logic             [COUNT_W-1:0]    out_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > POS_W) ? CW : POS_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(DEPTH);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_r;

  logic [FUNC_W-1:0]      func_r;
  logic [VALUE_WIDTH-1:0] key_r;
  logic [POS_W-1:0]       pos_r;

  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                found_r, found_nxt;

  logic [STATUS_W-1:0] out_status_r;
  logic                out_found_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic                   full, empty, pos_ok;
  logic [AW-1:0]          head_inc, head_dec, pos_m1, slot_off, slot;
  logic [AW:0]            slot_sum;
  logic                   we;
  logic [AW-1:0]          waddr;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign pos_ok   = (pos_r != '0) && (MW'(pos_r) <= MW'(cnt_r));
  assign pos_m1   = AW'(pos_r - POS_W'(1));
  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + AW'(1);
  assign head_dec = (head_r == '0) ? LAST_SLOT : head_r - AW'(1);

  always_comb begin
    if (cmd.step) begin
      slot_off = idx_r[AW-1:0];
    end else begin
      case (func_r)
        FN_PUSH_BACK: slot_off = cnt_r[AW-1:0];
        FN_REPLACE:   slot_off = pos_m1;
        default:      slot_off = '0;
      endcase
    end
  end

  assign slot_sum = {1'b0, head_r} + {1'b0, slot_off};
  assign slot     = (slot_sum >= DEPTH_X) ? AW'(slot_sum - DEPTH_X) : slot_sum[AW-1:0];

  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    we         = 1'b0;
    waddr      = slot;
    if (cmd.exec) begin
      status_nxt = ST_OK;
      found_nxt  = 1'b0;
      case (func_r)
        FN_PUSH_FRONT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            head_nxt = head_dec;
            waddr    = head_dec;
            we       = 1'b1;
            cnt_nxt  = cnt_r + CW'(1);
          end
        end
        FN_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            we      = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        FN_POP_FRONT: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            head_nxt = head_inc;
            cnt_nxt  = cnt_r - CW'(1);
          end
        end
        FN_POP_BACK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
        FN_REPLACE: begin
          if (pos_ok) begin
            we = 1'b1;
          end else begin
            status_nxt = ST_BADPOS;
          end
        end
        FN_SEARCH: begin
          idx_nxt = CW'(1);
        end
        default: begin
        end
      endcase
    end
    if (cmd.step) begin
      idx_nxt = idx_r + CW'(1);
      if (st.hit) begin
        found_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= key_r;
    end
    rdata_r <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      key_r  <= VALUE_WIDTH'(in_value);
      pos_r  <= in_position;
    end
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_found_r  <= found_r;
      out_count_r  <= COUNT_W'(cnt_r);
    end
  end

  assign st.is_search = (func_r == FN_SEARCH);
  assign st.empty     = empty;
  assign st.hit       = (rdata_r == key_r);
  assign st.last      = (idx_r == cnt_r);

  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_count  = out_count_r;

  `BLDQ_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= FULL_CNT, "entry count above depth")
  `BLDQ_ASSERT(a_head_bound, clk, rst_n, head_r <= LAST_SLOT, "head index outside ring")
  `BLDQ_ASSERT_NEXT(a_full_hold, clk, rst_n, cmd.exec && full && (func_r == FN_PUSH_FRONT || func_r == FN_PUSH_BACK), $stable(cnt_r) && $stable(head_r) && status_r == ST_FULL, "push on full ring changed state")

endmodule

`default_nettype wire

[hw/rtl/bounded_list_deque_engine_unit.sv]
// Bounded double-ended queue with search, DEPTH entries of VALUE_WIDTH bits in a ring.
// Input channel in_*: one request per accepted beat; in_tdata carries func, value
// and position. Output channel out_*: one result per request with status, found
// flag and the entry count after the request, in request order.
// Push, pop, replace and count pass from acceptance through the execute and done
// states to out_tvalid, and the next request is taken back in the idle state. Search
// adds a search state, skipped for an empty ring, that reads the stored entries one
// per cycle through the entry memory's single read port and stops at the first match.
// One request is worked at a time; a new request is taken while the previous
// result still waits in the output register.
// Reset empties the ring (count and head cleared); entry contents are not cleared,
// and no unwritten entry reaches a result. When the receiver stalls, the result holds
// on out_tdata, the next request completes internally and then waits, and
// in_tready stays low until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module bounded_list_deque_engine_unit
  import bldq_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // func[2:0], value[34:3], position[39:35]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata   // status[1:0], found[2], count[7:3]
);

  bldq_cmd_t           cmd;
  bldq_stat_t          st;
  logic [STATUS_W-1:0] out_status;
  logic                out_found;
  logic [COUNT_W-1:0]  out_count;

  bldq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .st         (st)
  );

  bldq_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_func     (in_tdata[2:0]),
    .in_value    (in_tdata[34:3]),
    .in_position (in_tdata[39:35]),
    .cmd         (cmd),
    .st          (st),
    .out_status  (out_status),
    .out_found   (out_found),
    .out_count   (out_count)
  );

  assign out_tdata = {out_count, out_found, out_status};

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import bldq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int MAX_GAP = 18;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SINK_HOLD_CYCLES = 160;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic                found;
    logic [STATUS_W-1:0] status;
  } deque_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [VALUE_IN_W-1:0] list_mem [DEPTH];
  logic [SLOT_W-1:0] list_head = '0;
  logic [COUNT_W-1:0] list_count = '0;

  deque_result_t pending_results[$];

  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;
  bit sink_hold = 1'b0;
  int error_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int search_hits = 0;
  int input_stall_cycles = 0;
  int cycle_count = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  bounded_list_deque_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_tvalid && !in_tready) begin
      input_stall_cycles <= input_stall_cycles + 1;
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("bounded_list_deque_engine_unit regression: fail");
      $finish;
    end
  end

  function automatic int draw_gap(input bit quiet);
    if (quiet) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic deque_result_t predict_request(input logic [FUNC_W-1:0] func_code,
                                                    input logic [VALUE_IN_W-1:0] val,
                                                    input logic [POS_W-1:0] pos);
    deque_result_t res;
    logic [SLOT_W-1:0] slot;
    int i;
    res.status = ST_OK;
    res.found = 1'b0;
    case (func_code)
      FN_PUSH_FRONT: begin
        if (list_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_head = list_head - 1'b1;
          list_mem[list_head] = val;
          list_count = list_count + 1'b1;
        end
      end
      FN_PUSH_BACK: begin
        if (list_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = list_head + SLOT_W'(list_count);
          list_mem[slot] = val;
          list_count = list_count + 1'b1;
        end
      end
      FN_POP_FRONT: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          list_head = list_head + 1'b1;
          list_count = list_count - 1'b1;
        end
      end
      FN_POP_BACK: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          list_count = list_count - 1'b1;
        end
      end
      FN_REPLACE: begin
        if (pos < 1 || pos > list_count) begin
          res.status = ST_BADPOS;
        end else begin
          slot = list_head + SLOT_W'(pos - 1'b1);
          list_mem[slot] = val;
        end
      end
      FN_SEARCH: begin
        for (i = 0; i < list_count; i++) begin
          slot = list_head + SLOT_W'(i);
          if (!res.found && list_mem[slot] == val) begin
            res.found = 1'b1;
          end
        end
        if (res.found) search_hits++;
      end
      default: begin
      end
    endcase
    res.count = list_count;
    status_seen[res.status]++;
    return res;
  endfunction

  task automatic send_request(input logic [FUNC_W-1:0] func_code,
                              input logic [VALUE_IN_W-1:0] val,
                              input logic [POS_W-1:0] pos);
    int gap;
    gap = draw_gap(in_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {pos, val, func_code};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_request(func_code, val, pos));
    requests_sent++;
  endtask

  task automatic wait_idle(input int extra);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d, %s: got %0d, expected %0d", results_checked, what,
             got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : result_check
    deque_result_t got;
    deque_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", got, -1);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.found !== want.found) report_mismatch("found", got.found, want.found);
        if (got.count !== want.count) report_mismatch("count", got.count, want.count);
      end
      results_checked++;
    end
  end

  initial begin : result_sink
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_gap(out_quiet);
      if (sink_hold) begin
        stall = stall + SINK_HOLD_CYCLES;
        sink_hold = 1'b0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic logic [VALUE_IN_W-1:0] pick_value();
    int r;
    logic [SLOT_W-1:0] slot;
    r = $urandom_range(0, 9);
    if (r < 3 && list_count > 0) begin
      slot = list_head + SLOT_W'($urandom_range(0, list_count - 1));
      return list_mem[slot];
    end
    if (r < 5) return VALUE_IN_W'($urandom_range(0, 7));
    if (r == 5) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom();
  endfunction

  task automatic test_empty_list();
    send_request(FN_POP_FRONT, 32'h0, 5'd0);
    send_request(FN_POP_BACK, 32'hffff_ffff, 5'd31);
    send_request(FN_REPLACE, 32'h1234_5678, 5'd1);
    send_request(FN_SEARCH, 32'h0, 5'd0);
    send_request(FN_COUNT, 32'h0, 5'd0);
    send_request(FN_UNUSED, 32'h5a5a_a5a5, 5'd16);
    wait_idle(DEPTH + 4);
  endtask

  task automatic test_full_list();
    int i;
    for (i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: send_request(FN_PUSH_BACK, 32'h7fff_ffff - i, 5'(i));
        1: send_request(FN_PUSH_FRONT, 32'h8000_0000 + i, 5'(i));
        2: send_request(FN_PUSH_BACK, 32'(i), 5'(i));
        default: send_request(FN_PUSH_FRONT, 32'hffff_ffff - i, 5'(i));
      endcase
    end
    send_request(FN_PUSH_BACK, 32'h1, 5'd0);
    send_request(FN_PUSH_FRONT, 32'h2, 5'd0);
    send_request(FN_REPLACE, 32'hffff_ffff, 5'(DEPTH));
    send_request(FN_REPLACE, 32'h0, 5'(DEPTH + 1));
    send_request(FN_REPLACE, 32'h0, 5'd0);
    send_request(FN_SEARCH, 32'h8000_0000, 5'd0);
    send_request(FN_SEARCH, 32'h8000_0000 + DEPTH - 1, 5'd31);
    send_request(FN_COUNT, 32'h0, 5'd0);
    wait_idle(DEPTH + 4);
  endtask

  task automatic test_sink_backpressure();
    int i;
    in_quiet = 1'b1;
    sink_hold = 1'b1;
    for (i = 0; i < 10; i++) begin
      if (list_count >= DEPTH - 2) begin
        send_request(FN_POP_FRONT, $urandom(), 5'd0);
      end else begin
        send_request(FN_PUSH_BACK, pick_value(), 5'd0);
      end
    end
    send_request(FN_SEARCH, pick_value(), 5'd0);
    send_request(FN_COUNT, 32'h0, 5'd0);
    in_quiet = 1'b0;
    wait_idle(DEPTH + 4);
  endtask

  task automatic test_random_traffic();
    int seg;
    int n;
    int r;
    int push_pct;
    logic [FUNC_W-1:0] fc;
    logic [POS_W-1:0] pos;
    for (seg = 0; seg < 10; seg++) begin
      in_quiet = (seg % 3 == 0);
      out_quiet = (seg % 4 == 1);
      push_pct = (seg % 2 == 0) ? 55 : 25;
      for (n = 0; n < 46; n++) begin
        r = $urandom_range(0, 99);
        pos = $urandom_range(0, 31);
        if (r < push_pct) begin
          fc = $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
        end else if (r < 80) begin
          fc = $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK;
        end else if (r < 88) begin
          fc = FN_REPLACE;
          if ($urandom_range(0, 4) != 0 && list_count > 0) pos = $urandom_range(1, list_count);
        end else if (r < 95) begin
          fc = FN_SEARCH;
        end else if (r < 98) begin
          fc = FN_COUNT;
        end else begin
          fc = FN_UNUSED;
        end
        send_request(fc, pick_value(), pos);
      end
    end
    in_quiet = 1'b0;
    out_quiet = 1'b0;
  endtask

  initial begin : run_tests
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_full_list();
    test_sink_backpressure();
    test_random_traffic();
    wait_idle(2 * DEPTH + 8);
    $display("%0d requests, %0d results checked; %0d search hits, input stalled %0d cycles",
             requests_sent, results_checked, search_hits, input_stall_cycles);
    $display("status ok %0d, empty %0d, full %0d, bad position %0d; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_BADPOS], error_count);
    if (error_count == 0) begin
      $display("bounded_list_deque_engine_unit regression: pass");
    end else begin
      $display("bounded_list_deque_engine_unit regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/bldq_pkg.sv
hw/rtl/bldq_ctrl.sv
hw/rtl/bldq_dp.sv
hw/rtl/bounded_list_deque_engine_unit.sv
tb/tb.sv
